/* rtl/saxpy_pkg.sv */
// Shared widths, codes and state encoding for the iterative saxpy block.
// No dependencies; compiled before every other file of the block.
package saxpy_pkg;

  localparam int VECTOR_DEPTH = 4096;
  localparam int ADDR_W       = $clog2(VECTOR_DEPTH);
  localparam int LEN_W        = ADDR_W + 1;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 12;
  localparam int DATA_W    = 32;
  localparam int ITER_W    = 16;
  localparam int VLEN_W    = 13;
  localparam int CFG_IDX_W = 1;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int FRAC_W    = 16;

  // running sum of up to VECTOR_DEPTH signed words
  localparam int SUM_W     = DATA_W + LEN_W;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  localparam logic [VLEN_W-1:0] VLEN_RESET = 13'd4096;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_ITERATE = 2'd1,
    OP_READ    = 2'd2
  } opcode_t;

  typedef enum logic {
    KIND_MEAN = 1'b0,
    KIND_READ = 1'b1
  } result_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_A       = 1'b0,
    REG_VECTOR_LENGTH = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ITER,
    ST_DIV,
    ST_DELIVER
  } state_t;

endpackage

/* rtl/saxpy_cmd_if.sv */
// Command channel of the saxpy block: valid/ready plus one command beat.
// Depends on saxpy_pkg for field widths.
interface saxpy_cmd_if;
  import saxpy_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [IDX_W-1:0]         element_index;
  logic signed [DATA_W-1:0] x_value;
  logic signed [DATA_W-1:0] y_value;

  modport source (output valid, opcode, element_index, x_value, y_value, input ready);
  modport sink   (input valid, opcode, element_index, x_value, y_value, output ready);
endinterface

/* rtl/saxpy_res_if.sv */
// Result channel of the saxpy block: valid/ready plus one result beat.
// Depends on saxpy_pkg for field widths.
interface saxpy_res_if;
  import saxpy_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     result_kind;
  logic signed [DATA_W-1:0] result_value;
  logic [ITER_W-1:0]        iteration_number;

  modport source (output valid, result_kind, result_value, iteration_number, input ready);
  modport sink   (input valid, result_kind, result_value, iteration_number, output ready);
endinterface

/* rtl/iterative_saxpy_with_mean_top.sv */
// Iterative saxpy with mean: write commands store an element; read commands return one
// through the output slot. An iterate command sweeps one element per cycle through
// the memory read port and then runs a one-bit-per-cycle restoring divider for the mean.
// Reset (rst, synchronous, active high) clears control, scale_a and the iteration count and
// sets vector_length to 4096; the X and Y memories are not cleared and are undefined until written.
module iterative_saxpy_with_mean_top (
  input  logic                                clk,
  input  logic                                rst,
  saxpy_cmd_if.sink                           cmd,
  saxpy_res_if.source                         res,
  input  logic                                cfg_we,
  input  logic [saxpy_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [saxpy_pkg::DATA_W-1:0]        cfg_data
);
  import saxpy_pkg::*;

  // Saturation bounds of a signed 32-bit word, held at product width.
  localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

  // ---------------------------------------------------------------------------
  // State and registers
  // ---------------------------------------------------------------------------
  state_t state, state_next;

  logic signed [DATA_W-1:0] scale_a;
  logic [VLEN_W-1:0]        vector_length;
  logic [ITER_W-1:0]        iter_count;

  // Vector storage: one synchronous memory each for X and Y, registered read.
  logic [DATA_W-1:0] x_mem [VECTOR_DEPTH];
  logic [DATA_W-1:0] y_mem [VECTOR_DEPTH];
  logic [DATA_W-1:0] x_rd;
  logic [DATA_W-1:0] y_rd;

  // Iteration sweep: issue counter and a three-stage read-modify-write pipe.
  logic [LEN_W-1:0]         len;
  logic [LEN_W-1:0]         issue_cnt;
  logic                     s1_vld;
  logic [ADDR_W-1:0]        s1_addr;
  logic                     s2_vld;
  logic [ADDR_W-1:0]        s2_addr;
  logic signed [DATA_W-1:0] s2_y;
  logic signed [PROD_W-1:0] s2_prod;
  logic                     s3_vld;
  logic [ADDR_W-1:0]        s3_addr;
  logic signed [DATA_W-1:0] s3_y;
  logic signed [SUM_W-1:0]  sum;

  // Serial divider for the mean (magnitude, sign restored at the end).
  logic [SUM_W-1:0]     div_q;
  logic [LEN_W-1:0]     div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_neg;

  // Staged result and output slot.
  logic                     read_ok;
  logic                     pend_kind;
  logic signed [DATA_W-1:0] pend_value;
  logic                     out_valid;
  logic                     out_kind;
  logic signed [DATA_W-1:0] out_value;
  logic [ITER_W-1:0]        out_iter;

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  logic                     cmd_fire;
  logic                     cmd_in_range;
  logic [LEN_W-1:0]         len_sat;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wr_addr;
  logic                     x_we;
  logic                     y_we;
  logic [DATA_W-1:0]        y_wdata;
  logic signed [PROD_W-1:0] prod_full;
  logic signed [PROD_W-1:0] upd_full;
  logic signed [DATA_W-1:0] upd_sat;
  logic [LEN_W:0]           rem_sh;
  logic                     rem_ge;
  logic [LEN_W:0]           rem_sub;
  logic [DATA_W-1:0]        mean_mag;
  logic                     issue;
  logic                     iter_done;
  logic                     div_done;
  logic                     load_out;

  assign cmd_fire     = cmd.valid && cmd.ready;
  assign cmd_in_range = 32'(cmd.element_index) < 32'(VECTOR_DEPTH);

  // Clamp the configured length to the memory depth.
  assign len_sat = (32'(vector_length) > 32'(VECTOR_DEPTH)) ? LEN_W'(VECTOR_DEPTH)
                                                            : LEN_W'(vector_length);

  // Read port: the sweep counter while iterating, else the command's index.
  assign rd_addr = (state == ST_ITER) ? issue_cnt[ADDR_W-1:0]
                                      : ADDR_W'(cmd.element_index);

  // Write port: sweep write-back while iterating, else a write command. The two
  // never coincide, since commands are taken only in idle. The sweep always writes
  // an element already read, so no forwarding is needed.
  assign x_we    = cmd_fire && (cmd.opcode == OP_WRITE) && cmd_in_range;
  assign y_we    = x_we || s3_vld;
  assign wr_addr = s3_vld ? s3_addr : ADDR_W'(cmd.element_index);
  assign y_wdata = s3_vld ? s3_y : cmd.y_value;

  // Stage 1 -> 2: full Q32.32 product.
  assign prod_full = scale_a * $signed(x_rd);

  // Stage 2 -> 3: floor shift back to Q16.16, add, saturate.
  assign upd_full = PROD_W'(s2_y) + (s2_prod >>> FRAC_W);
  always_comb begin
    if (upd_full > SAT_MAX) begin
      upd_sat = DATA_W'(SAT_MAX);
    end else if (upd_full < SAT_MIN) begin
      upd_sat = DATA_W'(SAT_MIN);
    end else begin
      upd_sat = DATA_W'(upd_full);
    end
  end

  // One restoring-division step.
  assign rem_sh   = {div_rem, div_q[SUM_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, len};
  assign rem_sub  = rem_sh - {1'b0, len};
  assign mean_mag = div_q[DATA_W-1:0];

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          case (cmd.opcode)
            OP_ITERATE: state_next = ST_ITER;
            OP_READ:    state_next = ST_READ;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ:    state_next = ST_DELIVER;
      ST_ITER: begin
        if (iter_done) begin
          state_next = (len == '0) ? ST_DELIVER : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (!out_valid || res.ready) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    cmd.ready = (state == ST_IDLE);
    issue     = (state == ST_ITER) && (issue_cnt != len);
    iter_done = (state == ST_ITER) && (issue_cnt == len) && !s1_vld && !s2_vld && !s3_vld;
    div_done  = (state == ST_DIV) && (div_cnt == DIV_CNT_W'(SUM_W));
    load_out  = (state == ST_DELIVER) && (!out_valid || res.ready);
  end

  assign res.valid            = out_valid;
  assign res.result_kind      = out_kind;
  assign res.result_value     = out_value;
  assign res.iteration_number = out_iter;

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (x_we) begin
      x_mem[wr_addr] <= cmd.x_value;
    end
    x_rd <= x_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (y_we) begin
      y_mem[wr_addr] <= y_wdata;
    end
    y_rd <= y_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      scale_a       <= '0;
      vector_length <= VLEN_RESET;
      iter_count    <= '0;
      issue_cnt     <= '0;
      s1_vld        <= 1'b0;
      s2_vld        <= 1'b0;
      s3_vld        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_SCALE_A:       scale_a       <= cfg_data;
          REG_VECTOR_LENGTH: vector_length <= cfg_data[VLEN_W-1:0];
          default:           ;
        endcase
      end

      // Advance the count when the iterate beat is taken; the mean carries it.
      if (cmd_fire && (cmd.opcode == OP_ITERATE)) begin
        iter_count <= iter_count + 1'b1;
        issue_cnt  <= '0;
      end else if (issue) begin
        issue_cnt <= issue_cnt + 1'b1;
      end

      s1_vld <= issue;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    s1_addr <= issue_cnt[ADDR_W-1:0];
    s2_addr <= s1_addr;
    s2_y    <= $signed(y_rd);
    s2_prod <= prod_full;
    s3_addr <= s2_addr;
    s3_y    <= upd_sat;

    if (cmd_fire) begin
      len     <= len_sat;
      sum     <= '0;
      read_ok <= cmd_in_range;
    end else if (s3_vld) begin
      sum <= sum + SUM_W'(s3_y);
    end

    // Load the divider with |sum| once the sweep has drained.
    if (iter_done) begin
      div_q   <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      div_neg <= sum[SUM_W-1];
      div_rem <= '0;
      div_cnt <= '0;
    end else if ((state == ST_DIV) && !div_done) begin
      div_q   <= {div_q[SUM_W-2:0], rem_ge};
      div_rem <= rem_ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
      div_cnt <= div_cnt + 1'b1;
    end

    // Stage the pending result.
    if (state == ST_READ) begin
      pend_kind  <= KIND_READ;
      pend_value <= read_ok ? $signed(y_rd) : '0;
    end else if (iter_done && (len == '0)) begin
      pend_kind  <= KIND_MEAN;
      pend_value <= '0;
    end else if (div_done) begin
      pend_kind  <= KIND_MEAN;
      pend_value <= div_neg ? $signed(-mean_mag) : $signed(mean_mag);
    end

    if (load_out) begin
      out_kind  <= pend_kind;
      out_value <= pend_value;
      out_iter  <= iter_count;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  // The write-back address always trails the read sweep.
  a_wb_behind_read: assert property (@(posedge clk) disable iff (rst)
    s3_vld |-> (LEN_W'(s3_addr) < issue_cnt))
    else $error("sweep write-back not behind read address");

  // Divider remainder stays below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_rem < len))
    else $error("divider remainder out of range");

  // An iterate beat advances the iteration count by one.
  a_iter_count: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && (cmd.opcode == OP_ITERATE)) |=>
      (iter_count == ITER_W'($past(iter_count) + 1'b1)))
    else $error("iteration count did not advance");

  // The sweep pipeline is empty whenever a command can be taken.
  a_pipe_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!s1_vld && !s2_vld && !s3_vld))
    else $error("sweep pipeline busy in idle");
`endif

endmodule
